FILE: design/tmps_pkg.sv
// shared types and sizes for the triangle maximum path sum block
// used by every module under design/ except tmps_row_ram; depends on nothing

package tmps_pkg;

	// sizing
	localparam int MAX_ROWS   = 512;
	localparam int ENTRY_BITS = 16;
	localparam int SUM_BITS   = 25;
	localparam int CFG_BITS   = 10;
	localparam int ROW_BITS   = $clog2(MAX_ROWS);
	localparam int LIM_BITS   = ROW_BITS + 1;
	localparam int CMP_BITS   = (CFG_BITS > LIM_BITS) ? CFG_BITS : LIM_BITS;
	localparam int EXT_BITS   = ((ENTRY_BITS > SUM_BITS) ? ENTRY_BITS : SUM_BITS) + 1;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	// one entry as it travels from the position stage to the sum stage
	typedef struct packed {
		logic [ENTRY_BITS-1:0] value;
		logic [ROW_BITS-1:0]   col;
		logic                  have_left;
		logic                  have_right;
		logic                  tri_end;
	} item_t;

endpackage

FILE: design/tmps_row_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read data; no package dependency

module tmps_row_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 25
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: design/tmps_front.sv
// position tracking and row count register for the triangle path sum block
// loads the sum-stage item register; depends on tmps_pkg

module tmps_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              row_count_we,
	input  logic [tmps_pkg::CFG_BITS-1:0]     row_count,
	input  logic                              accept,
	input  logic                              hold,
	input  logic [tmps_pkg::ENTRY_BITS-1:0]   entry_value,
	output logic [tmps_pkg::ROW_BITS-1:0]     rd_addr,
	output logic                              valid_s1,
	output tmps_pkg::item_t                   item_s1
);

	logic [tmps_pkg::CFG_BITS-1:0] row_count_q;
	logic [tmps_pkg::ROW_BITS-1:0] row_q;
	logic [tmps_pkg::ROW_BITS-1:0] col_q;
	logic [tmps_pkg::CMP_BITS-1:0] cnt_ext;
	logic [tmps_pkg::LIM_BITS-1:0] rows_use;
	logic [tmps_pkg::LIM_BITS-1:0] row_next;
	logic                          row_end;
	logic                          tri_end;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= tmps_pkg::CFG_BITS'(1);
		end else if (row_count_we) begin
			row_count_q <= row_count;
		end
	end

	// clamp the row count to 1..MAX_ROWS
	always_comb begin
		cnt_ext = tmps_pkg::CMP_BITS'(row_count_q);
		if (cnt_ext == '0) begin
			rows_use = tmps_pkg::LIM_BITS'(1);
		end else if (cnt_ext > tmps_pkg::CMP_BITS'(tmps_pkg::MAX_ROWS)) begin
			rows_use = tmps_pkg::LIM_BITS'(tmps_pkg::MAX_ROWS);
		end else begin
			rows_use = tmps_pkg::LIM_BITS'(cnt_ext);
		end
	end

	// end of row and end of triangle for the entry at the port
	assign row_next = tmps_pkg::LIM_BITS'(row_q) + tmps_pkg::LIM_BITS'(1);
	assign row_end  = (col_q == row_q);
	assign tri_end  = row_end && (row_next >= rows_use);
	assign rd_addr  = col_q;

	// row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (tri_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (row_end) begin
				row_q <= row_next[tmps_pkg::ROW_BITS-1:0];
				col_q <= '0;
			end else begin
				col_q <= col_q + tmps_pkg::ROW_BITS'(1);
			end
		end
	end

	// sum-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || hold;
		end
	end

	// sum-stage item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.value      <= entry_value;
			item_s1.col        <= col_q;
			item_s1.have_left  <= (row_q != '0) && (col_q != '0);
			item_s1.have_right <= !row_end;
			item_s1.tri_end    <= tri_end;
		end
	end

endmodule

FILE: design/tmps_accum.sv
// sum stage: parent select, add, row store write-back, best tracking
// and result register; depends on tmps_pkg

module tmps_accum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  tmps_pkg::item_t                 item_s1,
	input  logic [tmps_pkg::SUM_BITS-1:0]   rd_data,
	input  logic [tmps_pkg::ROW_BITS-1:0]   rd_addr,
	input  logic                            accept,
	input  logic                            result_stall,
	output logic                            hold,
	output logic                            wr_en,
	output logic [tmps_pkg::ROW_BITS-1:0]   wr_addr,
	output logic [tmps_pkg::SUM_BITS-1:0]   wr_data,
	output logic                            result_valid,
	output logic [tmps_pkg::SUM_BITS-1:0]   max_path_sum
);

	logic                          fwd_q;
	logic [tmps_pkg::SUM_BITS-1:0] fwd_data_q;
	logic [tmps_pkg::SUM_BITS-1:0] left_hold_q;
	logic [tmps_pkg::SUM_BITS-1:0] best_q;
	logic                          result_valid_q;
	logic [tmps_pkg::SUM_BITS-1:0] result_q;

	logic [tmps_pkg::SUM_BITS-1:0] old_sum;
	logic [tmps_pkg::SUM_BITS-1:0] left;
	logic [tmps_pkg::SUM_BITS-1:0] right;
	logic [tmps_pkg::SUM_BITS-1:0] parent;
	logic [tmps_pkg::EXT_BITS-1:0] sum_ext;
	logic [tmps_pkg::SUM_BITS-1:0] sum;
	logic [tmps_pkg::SUM_BITS-1:0] best_next;
	logic                          fire;

	// parent select with forwarding of the previous write
	always_comb begin
		old_sum = fwd_q ? fwd_data_q : rd_data;
		left    = item_s1.have_left  ? left_hold_q : '0;
		right   = item_s1.have_right ? old_sum     : '0;
		parent  = (right > left) ? right : left;
	end

	// saturating add and running maximum
	always_comb begin
		sum_ext = tmps_pkg::EXT_BITS'(item_s1.value) + tmps_pkg::EXT_BITS'(parent);
		if (sum_ext > tmps_pkg::EXT_BITS'(tmps_pkg::SUM_MAX)) begin
			sum = tmps_pkg::SUM_MAX;
		end else begin
			sum = sum_ext[tmps_pkg::SUM_BITS-1:0];
		end
		best_next = (sum > best_q) ? sum : best_q;
	end

	// stall only a triangle end that finds the result register busy
	assign hold    = valid_s1 && item_s1.tri_end && result_valid_q && result_stall;
	assign fire    = valid_s1 && !hold;
	assign wr_en   = fire;
	assign wr_addr = item_s1.col;
	assign wr_data = sum;

	// forwarding for a read of the address being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (accept) begin
			fwd_q <= fire && (rd_addr == item_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_q <= sum;
		end
	end

	// left parent and best sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hold_q <= '0;
			best_q      <= '0;
		end else if (fire) begin
			left_hold_q <= right;
			best_q      <= item_s1.tri_end ? '0 : best_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && item_s1.tri_end) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.tri_end) begin
			result_q <= best_next;
		end
	end

	assign result_valid = result_valid_q;
	assign max_path_sum = result_q;

	// a finished triangle shows its maximum in the next cycle
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.tri_end) |=> (result_valid_q && result_q == $past(best_next)))
		else $error("result not loaded after triangle end");

	// a new triangle starts from a clean state
	a_tri_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.tri_end) |=> (best_q == '0 && left_hold_q == '0))
		else $error("state not cleared after triangle end");

	// forwarding only follows a write in the previous cycle
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_q) |-> $past(wr_en))
		else $error("forward without a preceding write");

	// a stalled sum stage blocks new transactions
	a_hold_block: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !accept)
		else $error("transaction accepted while sum stage holds");

endmodule

FILE: design/triangle_max_path_sum.sv
// triangle maximum path sum: one entry per cycle unless stalled, one result per triangle
// result: the final entry passes the sum-stage item register, then loads the result register
// throughput: one entry per cycle while entry_stall is low, bounded by the single row-store read and write;
// entry_stall rises only when a triangle-ending entry meets an occupied, stalled result
// reset: counters, running best and result valid clear, row_count becomes 1;
// the row store is not cleared, every read follows a write of the same triangle

module triangle_max_path_sum (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              row_count_we,
	input  logic [tmps_pkg::CFG_BITS-1:0]     row_count,
	input  logic                              entry_valid,
	output logic                              entry_stall,
	input  logic [tmps_pkg::ENTRY_BITS-1:0]   entry_value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [tmps_pkg::SUM_BITS-1:0]     max_path_sum
);

	logic                          accept;
	logic                          hold;
	logic                          valid_s1;
	tmps_pkg::item_t               item_s1;
	logic [tmps_pkg::ROW_BITS-1:0] front_addr;
	logic [tmps_pkg::ROW_BITS-1:0] ram_rd_addr;
	logic [tmps_pkg::SUM_BITS-1:0] ram_rd_data;
	logic                          wr_en;
	logic [tmps_pkg::ROW_BITS-1:0] wr_addr;
	logic [tmps_pkg::SUM_BITS-1:0] wr_data;

	// input transaction
	assign entry_stall = hold;
	assign accept      = entry_valid && !hold;

	// re-read the held entry's address while the sum stage waits
	assign ram_rd_addr = hold ? item_s1.col : front_addr;

	tmps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_count_we (row_count_we),
		.row_count    (row_count),
		.accept       (accept),
		.hold         (hold),
		.entry_value  (entry_value),
		.rd_addr      (front_addr),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	tmps_row_ram #(
		.DEPTH (tmps_pkg::MAX_ROWS),
		.WIDTH (tmps_pkg::SUM_BITS)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	tmps_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.rd_data      (ram_rd_data),
		.rd_addr      (front_addr),
		.accept       (accept),
		.result_stall (result_stall),
		.hold         (hold),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.result_valid (result_valid),
		.max_path_sum (max_path_sum)
	);

endmodule
